// ===== rtl/twbp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// twbp_pkg: shared types and constants of the per-type window byte policer
// item layouts, table entry layout and fixed policing constants
// ----------------------------------------------------------------------------
package twbp_pkg;

    localparam int          NUM_TYPES_DEF = 1024;
    localparam logic [15:0] BUDGET_RESET  = 16'd2048;
    localparam logic [4:0]  HEADER_BYTES  = 5'd12;
    localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;
    localparam int          QUOT_BITS     = 32;

    localparam logic MODE_MSG   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [9:0]  msg_type;
        logic [31:0] time_sec;
        logic [11:0] payload_len;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic [31:0] window_count;
        logic [31:0] message_count;
        logic [31:0] average;
    } out_item_t;

    // one table row per message type
    typedef struct packed {
        logic        seen;
        logic [31:0] last_stamp;
        logic [15:0] window_bytes;
        logic [31:0] windows_opened;
        logic [31:0] messages_accepted;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + 32'd1;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/twbp_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// twbp_ram: generic single write port ram
// one write and one read per cycle, read data registered
// ----------------------------------------------------------------------------
module twbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/per_type_window_byte_policer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// per_type_window_byte_policer_top: per-type fixed-window byte policer
// polices message bytes per type and second, answers statistics queries
// ----------------------------------------------------------------------------
// usage
//   in channel: in_valid / in_stall / in_data, a transfer when valid and not
//   stalled. mode 0 is a message (type, second stamp, payload length), mode 1
//   a statistics query for a type. every transfer yields one out transfer
//   carrying accepted, window and message counts and their quotient.
//   cfg_wr_en / cfg_wr_data write the byte budget; write only while idle.
// sequence
//   one item at a time: read of the type's table row, an update step, then
//   the shared restoring divider forms the quotient bit by bit. an item
//   with no window skips the divider.
// reset
//   after rst_n rises, a clearing pass zeroes the table, one row per cycle,
//   over all NUM_TYPES rows; in_stall stays high during it. budget resets to 2048.
// stall
//   a finished result sits in the output register; the next item is taken
//   meanwhile and its result waits until the register is free.
// ----------------------------------------------------------------------------
module per_type_window_byte_policer_top
    import twbp_pkg::*;
#(
    parameter int NUM_TYPES = NUM_TYPES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire in_item_t    in_data,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      out_item_t   out_data,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    localparam int AW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int CW = $clog2(QUOT_BITS);

    // one-hot sequencer
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_CALC  = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [15:0]     budget_reg, budget_next;
    in_item_t        item_reg, item_next;
    logic            acc_reg, acc_next;
    logic [31:0]     wc_reg, wc_next;
    logic [31:0]     mc_reg, mc_next;
    logic [31:0]     quot_reg, quot_next;
    logic [31:0]     rem_reg, rem_next;
    logic [CW-1:0]   div_cnt_reg, div_cnt_next;
    logic            out_valid_reg, out_valid_next;
    out_item_t       out_reg, out_next;

    // table port
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    entry_t          ram_wdata;
    logic            ram_re;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t          row;

    // update datapath
    logic            type_ok;
    logic [AW-1:0]   item_addr;
    logic            open_win;
    logic [15:0]     base_bytes;
    logic [31:0]     win_upd;
    logic [16:0]     new_sum;
    logic            fits;

    // divider step
    logic [32:0]     rem_shift;
    logic [33:0]     rem_diff;
    logic            rem_ge;

    twbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_TYPES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (item_addr),
        .rdata (ram_rdata)
    );

    assign row       = entry_t'(ram_rdata);
    assign type_ok   = ({22'd0, item_reg.msg_type} < 32'(NUM_TYPES));
    assign item_addr = AW'(item_reg.msg_type);

    // window and budget decision for a message
    assign open_win   = !row.seen || (row.last_stamp != item_reg.time_sec);
    assign base_bytes = open_win ? 16'd0 : row.window_bytes;
    assign win_upd    = open_win ? sat_inc(row.windows_opened) : row.windows_opened;
    assign new_sum    = {1'b0, base_bytes} + {12'd0, HEADER_BYTES}
                      + {5'd0, item_reg.payload_len};
    assign fits       = (new_sum <= {1'b0, budget_reg});

    // restoring division, one quotient bit per cycle
    assign rem_shift = {rem_reg, quot_reg[QUOT_BITS-1]};
    assign rem_diff  = {1'b0, rem_shift} - {2'b00, wc_reg};
    assign rem_ge    = !rem_diff[33];

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        budget_next    = cfg_wr_en ? cfg_wr_data : budget_reg;
        item_next      = item_reg;
        acc_next       = acc_reg;
        wc_next        = wc_reg;
        mc_next        = mc_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = item_addr;
        ram_wdata      = '0;
        ram_re         = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(NUM_TYPES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                acc_next = 1'b0;
                wc_next  = '0;
                mc_next  = '0;
                if (type_ok)
                begin
                    if (item_reg.mode == MODE_MSG)
                    begin
                        ram_we                   = 1'b1;
                        ram_wdata.seen           = 1'b1;
                        ram_wdata.last_stamp     = item_reg.time_sec;
                        ram_wdata.window_bytes   = fits ? new_sum[15:0] : base_bytes;
                        ram_wdata.windows_opened = win_upd;
                        ram_wdata.messages_accepted = fits ? sat_inc(row.messages_accepted)
                                                           : row.messages_accepted;
                        acc_next = fits;
                        wc_next  = win_upd;
                        mc_next  = ram_wdata.messages_accepted;
                    end
                    else
                    begin
                        wc_next = row.windows_opened;
                        mc_next = row.messages_accepted;
                    end
                end
                quot_next    = mc_next;
                rem_next     = '0;
                div_cnt_next = '0;
                // no window means quotient zero, skip the divider
                state_next   = (wc_next == 32'd0) ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                rem_next     = rem_ge ? rem_diff[31:0] : rem_shift[31:0];
                quot_next    = {quot_reg[QUOT_BITS-2:0], rem_ge};
                div_cnt_next = div_cnt_reg + CW'(1);
                if (div_cnt_reg == CW'(QUOT_BITS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next         = 1'b1;
                    out_next.accepted      = acc_reg;
                    out_next.window_count  = wc_reg;
                    out_next.message_count = mc_reg;
                    out_next.average       = (wc_reg == 32'd0) ? 32'd0 : quot_reg;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            budget_reg    <= BUDGET_RESET;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            budget_reg    <= budget_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        acc_reg  <= acc_next;
        wc_reg   <= wc_next;
        mc_reg   <= mc_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        out_reg  <= out_next;
    end

endmodule
`default_nettype wire

// ===== rtl/twbp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// twbp_checker: port-level checks of the per-type window byte policer
// watches the item and result channels over time
// ----------------------------------------------------------------------------
module twbp_checker
    import twbp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire out_item_t   out_data
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // one item at a time: busy right after a transfer
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    // no window means nothing accepted, zero message count and zero quotient
    a_no_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.window_count == 32'd0) |->
            !out_data.accepted && (out_data.message_count == 32'd0)
            && (out_data.average == 32'd0))
        else $error("counts without a window");

    // quotient never exceeds the dividend
    a_avg_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.average <= out_data.message_count)
        else $error("average above message count");

    // an accepted message leaves nonzero window and message counts
    a_accept_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.accepted |->
            (out_data.message_count != 32'd0) && (out_data.window_count != 32'd0))
        else $error("accepted message with zero counts");

endmodule

bind per_type_window_byte_policer_top twbp_checker u_twbp_checker (.*);
`default_nettype wire
